@@ rtl/positional_insert_range_min_macros.svh @@
// Assertion macros shared by the positional insert and range minimum block.
`ifndef POSITIONAL_INSERT_RANGE_MIN_MACROS_SVH
`define POSITIONAL_INSERT_RANGE_MIN_MACROS_SVH

// Checked on every rising clock edge, including during reset.
`define PIRM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

// Checked on every rising clock edge outside reset.
`define PIRM_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

@@ rtl/pirm_pkg.sv @@
// Types and constants shared by the positional insert and range minimum block.
package pirm_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int POS_W = 17;

	localparam logic signed [31:0] SENTINEL = 32'sd2000000000;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_ANSWERED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic ins_en;
		pos_t ins_pos;
		pos_t q_lo;
		pos_t q_hi;
	} cell_ctrl_t;

endpackage

@@ rtl/positional_insert_range_min.sv @@
// Top level of the positional insert and range minimum block.
// The sequence lives in a chain of CAPACITY cells. At the accepting edge of an insert
// into a store that is not full, the cell at the insert position takes the new word and
// every cell after it takes its lower neighbour's word. Busy stays low, so a new word may
// be started on every cycle. Its result appears on the cycle after acceptance. A query
// with an empty range also answers on the next cycle. Any other query holds busy while
// the running minimum ripples through the chain one cell per cycle, and its result
// appears in the same cycle as busy falls. Each result is shown for one cycle with done
// high; the receiver cannot stall, so it must take every word as it comes.
module positional_insert_range_min import pirm_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [10:0]        insert_position,
	input  logic signed [31:0] new_value,
	input  logic [9:0]         query_left,
	input  logic [9:0]         query_right,
	output logic               done,
	output logic signed [31:0] range_min,
	output logic [1:0]         status
);

	`include "positional_insert_range_min_macros.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic IDLE  = 1'b0;
	localparam logic QUERY = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   wait_q;
	logic               done_q;
	pos_t               lo_q;
	pos_t               hi_q;
	logic signed [31:0] range_min_q;
	logic [1:0]         status_q;

	pos_t       cnt_ext;
	pos_t       pos_in;
	pos_t       pos_eff;
	pos_t       left_e;
	pos_t       right_e;
	pos_t       right_clip;
	logic       full;
	logic       empty;
	logic       accept;
	logic       finish;
	cell_ctrl_t ctrl;

	logic signed [31:0] val_w [CAPACITY];
	logic signed [31:0] min_w [CAPACITY];

	assign busy = (state_q == QUERY);
	assign accept = start && !busy;
	assign finish = (state_q == QUERY) && (wait_q == '0);

	assign cnt_ext = pos_t'(count_q);
	assign pos_in = pos_t'(insert_position);
	assign left_e = pos_t'(query_left);
	assign right_e = pos_t'(query_right);
	assign full = (cnt_ext == pos_t'(CAPACITY));
	assign pos_eff = (pos_in > cnt_ext) ? cnt_ext : pos_in;
	assign empty = (cnt_ext == '0) || (left_e >= cnt_ext) || (left_e > right_e);
	assign right_clip = (right_e >= cnt_ext) ? (cnt_ext - pos_t'(1)) : right_e;

	always_comb begin
		ctrl.ins_en = accept && !mode && !full;
		ctrl.ins_pos = pos_eff;
		ctrl.q_lo = lo_q;
		ctrl.q_hi = hi_q;
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [31:0] v_in;
		logic signed [31:0] m_in;
		if (k == 0) begin : g_head
			assign v_in = new_value;
			assign m_in = SENTINEL;
		end else begin : g_body
			assign v_in = val_w[k-1];
			assign m_in = min_w[k-1];
		end
		pirm_cell #(
			.INDEX(k)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.value_in (v_in),
			.new_value(new_value),
			.value_out(val_w[k]),
			.min_in   (m_in),
			.min_out  (min_w[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			wait_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (!mode || empty)) || finish;
			if (accept) begin
				if (!mode) begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end else if (!empty) begin
					state_q <= QUERY;
					wait_q <= CNT_W'(CAPACITY);
				end
			end else if (finish) begin
				state_q <= IDLE;
			end else if (state_q == QUERY) begin
				wait_q <= wait_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= left_e;
			hi_q <= right_clip;
			if (!mode) begin
				range_min_q <= '0;
				status_q <= full ? ST_FULL : ST_INSERTED;
			end else if (empty) begin
				range_min_q <= SENTINEL;
				status_q <= ST_EMPTY;
			end
		end else if (finish) begin
			range_min_q <= min_w[CAPACITY-1];
			status_q <= ST_ANSWERED;
		end
	end

	assign done = done_q;
	assign range_min = range_min_q;
	assign status = status_q;

	`PIRM_ASSERT_RST(a_count_bound, (count_q <= CNT_W'(CAPACITY)), "element count above capacity")
	`PIRM_ASSERT_RST(a_query_done, ($fell(busy) |-> done_q), "query ended without a result")
	`PIRM_ASSERT_RST(a_busy_quiet, (busy |-> !done_q), "result shown while a query runs")
	`PIRM_ASSERT_RST(a_ins_count, ((done_q && (status_q == ST_INSERTED)) |-> (count_q == $past(count_q) + 1'b1)), "insert did not grow the count")

endmodule

@@ rtl/pirm_cell.sv @@
// One storage cell of the sequence chain with its stage of the running minimum.
module pirm_cell import pirm_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic signed [31:0] value_in,
	input  logic signed [31:0] new_value,
	output logic signed [31:0] value_out,
	input  logic signed [31:0] min_in,
	output logic signed [31:0] min_out
);

	localparam pos_t IDX = pos_t'(INDEX);

	logic signed [31:0] value_q;
	logic signed [31:0] min_q;
	logic signed [31:0] cand;
	logic               in_rng;

	assign in_rng = (IDX >= ctrl.q_lo) && (IDX <= ctrl.q_hi);
	assign cand = in_rng ? value_q : SENTINEL;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (IDX == ctrl.ins_pos) begin
				value_q <= new_value;
			end else if (IDX > ctrl.ins_pos) begin
				value_q <= value_in;
			end
		end
		min_q <= (cand < min_in) ? cand : min_in;
	end

	assign value_out = value_q;
	assign min_out = min_q;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the positional insert and range minimum block.
`timescale 1ns / 100ps

module testbench import pirm_pkg::*; ();

	localparam int CAPACITY = DEF_CAPACITY;
	localparam int QUIET_LIMIT = 8 * CAPACITY;
	localparam int TAIL_CYCLES = CAPACITY + 20;
	localparam int RANDOM_WORDS = 550;
	localparam int MAX_PRINTED = 100;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
	localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

	typedef struct {
		logic               mode;
		logic [10:0]        position;
		logic signed [31:0] value;
		logic [9:0]         left;
		logic [9:0]         right;
		bit                 settle;
	} request_t;

	typedef struct {
		logic signed [31:0] minimum;
		logic [1:0]         status;
	} answer_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               mode = MODE_INSERT;
	logic [10:0]        insert_position = '0;
	logic signed [31:0] new_value = '0;
	logic [9:0]         query_left = '0;
	logic [9:0]         query_right = '0;
	logic               done;
	logic signed [31:0] range_min;
	logic [1:0]         status;

	request_t pending_words[$];
	answer_t  awaited_answers[$];

	logic signed [31:0] shadow_seq [CAPACITY];
	int shadow_len = 0;
	int gen_len = 0;
	int in_flight = 0;
	int errors = 0;
	int gap_left = 0;
	bit gap_on_idle = 1'b0;
	bit calm = 1'b0;

	positional_insert_range_min #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.insert_position(insert_position),
		.new_value(new_value),
		.query_left(query_left),
		.query_right(query_right),
		.done(done),
		.range_min(range_min),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	function automatic answer_t apply_and_answer(logic op, logic [10:0] at,
			logic signed [31:0] value, logic [9:0] lo, logic [9:0] hi);
		answer_t ans;
		int slot;
		int last;
		int k;
		logic signed [31:0] best;
		ans.minimum = '0;
		if (op == MODE_INSERT) begin
			if (shadow_len >= CAPACITY) begin
				ans.status = ST_FULL;
			end else begin
				slot = (int'(at) > shadow_len) ? shadow_len : int'(at);
				for (k = shadow_len; k > slot; k--)
					shadow_seq[k] = shadow_seq[k - 1];
				shadow_seq[slot] = value;
				shadow_len++;
				ans.status = ST_INSERTED;
			end
		end else if (shadow_len == 0 || int'(lo) >= shadow_len || lo > hi) begin
			ans.minimum = SENTINEL;
			ans.status = ST_EMPTY;
		end else begin
			last = (int'(hi) >= shadow_len) ? shadow_len - 1 : int'(hi);
			best = SENTINEL;
			for (k = int'(lo); k <= last; k++)
				if (shadow_seq[k] < best)
					best = shadow_seq[k];
			ans.minimum = best;
			ans.status = ST_ANSWERED;
		end
		return ans;
	endfunction

	function automatic void queue_insert(int at, logic signed [31:0] value, bit settle);
		request_t req;
		req.mode = MODE_INSERT;
		req.position = 11'(at);
		req.value = value;
		req.left = 10'($urandom);
		req.right = 10'($urandom);
		req.settle = settle;
		pending_words.push_back(req);
		if (gen_len < CAPACITY)
			gen_len++;
	endfunction

	function automatic void queue_query(int lo, int hi, bit settle);
		request_t req;
		req.mode = MODE_QUERY;
		req.position = 11'($urandom);
		req.value = $urandom;
		req.left = 10'(lo);
		req.right = 10'(hi);
		req.settle = settle;
		pending_words.push_back(req);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return MOST_NEGATIVE;
			1: return MOST_POSITIVE;
			2: return SENTINEL;
			3: return SENTINEL + 1;
			4, 5: return $urandom_range(0, 40) - 20;
			default: return $urandom;
		endcase
	endfunction

	function automatic void random_insert(bit settle);
		int roll;
		int at;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			at = $urandom_range(0, gen_len);
		else if (roll < 80)
			at = 0;
		else if (roll < 90)
			at = gen_len;
		else
			at = $urandom_range(0, 2047);
		queue_insert(at, pick_value(), settle);
	endfunction

	function automatic void random_query(bit settle);
		int roll;
		int lo;
		int hi;
		roll = $urandom_range(0, 99);
		if (gen_len == 0 || roll < 10) begin
			lo = $urandom_range(0, 1023);
			hi = $urandom_range(0, 1023);
		end else if (roll < 16) begin
			lo = $urandom_range(1, 1023);
			hi = $urandom_range(0, lo - 1);
		end else if (roll < 30) begin
			lo = $urandom_range(0, gen_len - 1);
			hi = $urandom_range(lo, 1023);
		end else if (roll < 50) begin
			lo = $urandom_range(0, gen_len - 1);
			hi = lo + $urandom_range(0, 3);
			if (hi > gen_len - 1)
				hi = gen_len - 1;
		end else begin
			lo = $urandom_range(0, gen_len - 1);
			hi = $urandom_range(lo, gen_len - 1);
		end
		queue_query(lo, hi, settle);
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		request_t req;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else if (!start || !busy) begin
			if (start) begin
				gap_left = pick_gap();
				gap_on_idle = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 29) == 0)
					calm = !calm;
			end
			if (gap_left > 0) begin
				if (!gap_on_idle || !busy)
					gap_left--;
				start <= 1'b0;
			end else if (pending_words.size() != 0 &&
					(!pending_words[0].settle || (!start && in_flight == 0))) begin
				req = pending_words.pop_front();
				start <= 1'b1;
				mode <= req.mode;
				insert_position <= req.position;
				new_value <= req.value;
				query_left <= req.left;
				query_right <= req.right;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		answer_t want;
		int change;
		change = 0;
		if (arst_n) begin
			if (done) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch("result word arrived with none awaited");
				end else begin
					want = awaited_answers.pop_front();
					change--;
					if (range_min !== want.minimum)
						report_mismatch($sformatf("range_min %0d, expected %0d",
							range_min, want.minimum));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
				end
			end
			if (start && !busy) begin
				awaited_answers.push_back(apply_and_answer(mode, insert_position,
					new_value, query_left, query_right));
				change++;
			end
		end
		in_flight <= in_flight + change;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : sequencer
		int n;
		// A short directed run over the empty store, the extremes and the clipped ranges.
		queue_query(0, 0, 1'b0);
		queue_query(1023, 1023, 1'b0);
		queue_insert(2047, MOST_NEGATIVE, 1'b0);
		queue_insert(0, MOST_POSITIVE, 1'b0);
		queue_insert(1, SENTINEL, 1'b0);
		queue_insert(1024, SENTINEL + 1, 1'b0);
		queue_insert(2, -1, 1'b0);
		queue_insert(5, 0, 1'b0);
		queue_query(0, 1023, 1'b0);
		queue_query(0, 0, 1'b0);
		queue_query(0, 1, 1'b0);
		queue_query(4, 4, 1'b0);
		queue_query(3, 2, 1'b0);
		queue_query(6, 9, 1'b0);
		queue_query(5, 1023, 1'b0);
		queue_query(2, 3, 1'b0);
		queue_query(1023, 0, 1'b0);
		queue_insert(3, 32'sh5555_5555, 1'b0);
		queue_insert(1536, 32'shAAAA_AAAA, 1'b0);
		queue_query(1, 7, 1'b0);

		for (n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 99) < 55)
				random_insert(n == 0 || $urandom_range(0, 99) == 0);
			else
				random_query(n == 0 || $urandom_range(0, 99) == 0);
		end

		// Fill the store to capacity, then check dropped inserts and queries over a full store.
		random_insert(1'b1);
		while (gen_len < CAPACITY)
			random_insert(1'b0);
		for (n = 0; n < 4; n++)
			random_insert(1'b0);
		queue_insert(2047, pick_value(), 1'b0);
		queue_query(0, 1023, 1'b0);
		queue_query(1023, 1023, 1'b0);
		queue_query(1023, 0, 1'b0);
		queue_query(0, 0, 1'b0);
		queue_query(511, 512, 1'b0);
		for (n = 0; n < 8; n++)
			random_query(1'b0);
		queue_insert(0, pick_value(), 1'b0);
		queue_query(1000, 1023, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_words.size() == 0);
		@(posedge clk);
		while (start || in_flight != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_answers.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				awaited_answers.size()));
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
